FILE: design/aescbc_pkg.sv
// aescbc_pkg: shared types, constants and round functions for the aes-128 cbc block.
// No dependencies. Used by aescbc_ctrl, aescbc_dp and aes128_cbc_block_cipher.
package aescbc_pkg;

  localparam int CfgIdxW = 8;
  localparam int NumRounds = 10;
  localparam int KeyIdxW = 4;

  localparam logic [CfgIdxW-1:0] REG_KEY_HIGH = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY_LOW  = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_IV_HIGH  = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_IV_LOW   = 8'd3;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  localparam logic [7:0] RC_FIRST = 8'h01;
  localparam logic [7:0] GF_POLY  = 8'h1b;

  localparam logic [2047:0] SBOX_TBL = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

  localparam logic [2047:0] ISBOX_TBL = {
    128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

  typedef struct packed {
    logic                accept;  // latch input beat
    logic                kinit;   // start key expansion from key registers
    logic                kstep;   // produce round key kidx
    logic                load;    // initial whitening
    logic                round;   // one cipher round
    logic                last;    // final round, write result
    logic [KeyIdxW-1:0]  kidx;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic mode;
    logic key_wr;
  } status_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    return SBOX_TBL[{~x, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    return ISBOX_TBL[{~x, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
  endfunction

  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    o = '0;
    for (int i = 0; i < 16; i++) begin
      o[8*i +: 8] = inv ? inv_sbox(s[8*i +: 8]) : sbox(s[8*i +: 8]);
    end
    return o;
  endfunction

  // byte i sits at bits 127-8i down
  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          o[8*(15-(r+4*((c+r)&3))) +: 8] = s[8*(15-(r+4*c)) +: 8];
        end else begin
          o[8*(15-(r+4*c)) +: 8] = s[8*(15-(r+4*((c+r)&3))) +: 8];
        end
      end
    end
    return o;
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] a, input logic inv);
    logic [7:0] b [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m1 [4];
    logic [7:0] m2 [4];
    logic [7:0] m3 [4];
    logic [31:0] o;
    for (int k = 0; k < 4; k++) begin
      b[k]  = a[8*(3-k) +: 8];
      x2[k] = xt(b[k]);
      x4[k] = xt(x2[k]);
      x8[k] = xt(x4[k]);
      // coefficient set: fwd {2,3,1,1}, inv {14,11,13,9}
      m1[k] = inv ? (x8[k] ^ x4[k] ^ x2[k]) : x2[k];
      m2[k] = inv ? (x8[k] ^ x2[k] ^ b[k]) : (x2[k] ^ b[k]);
      m3[k] = inv ? (x8[k] ^ x4[k] ^ b[k]) : b[k];
    end
    o = '0;
    for (int r = 0; r < 4; r++) begin
      o[8*(3-r) +: 8] = m1[r] ^ m2[(r+1)&3] ^ m3[(r+2)&3]
                        ^ (inv ? (x8[(r+3)&3] ^ b[(r+3)&3]) : b[(r+3)&3]);
    end
    return o;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      o[32*(3-c) +: 32] = mix_col(s[32*(3-c) +: 32], inv);
    end
    return o;
  endfunction

  function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] t;
    logic [31:0] n0, n1, n2, n3;
    t = {sbox(k[23:16]) ^ rc, sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])};
    n0 = k[127:96] ^ t;
    n1 = k[95:64] ^ n0;
    n2 = k[63:32] ^ n1;
    n3 = k[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

endpackage

FILE: design/aescbc_ctrl.sv
// aescbc_ctrl: sequencer for key expansion and the ten cipher rounds.
// Depends on aescbc_pkg.
module aescbc_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  aescbc_pkg::status_t     sts,
  output aescbc_pkg::cmd_t        cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_KEXP  = 4'b0010,
    S_LOAD  = 4'b0100,
    S_ROUND = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [aescbc_pkg::KeyIdxW-1:0] cnt_r, cnt_nxt;
  logic dirty_r, dirty_nxt;
  logic acc;
  logic last_rnd;

  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid & in_ready;
  assign last_rnd = (cnt_r == aescbc_pkg::KeyIdxW'(aescbc_pkg::NumRounds));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    dirty_nxt = dirty_r | sts.key_wr;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          cmd.accept = 1'b1;
          if (dirty_r) begin
            cmd.kinit = 1'b1;
            dirty_nxt = 1'b0;
            cnt_nxt   = aescbc_pkg::KeyIdxW'(1);
            state_nxt = S_KEXP;
          end else begin
            state_nxt = S_LOAD;
          end
        end
      end
      S_KEXP: begin
        cmd.kstep = 1'b1;
        cmd.kidx  = cnt_r;
        cnt_nxt   = cnt_r + 1'b1;
        if (last_rnd) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        cmd.kidx  = (sts.mode == aescbc_pkg::MODE_DEC)
                    ? aescbc_pkg::KeyIdxW'(aescbc_pkg::NumRounds) : '0;
        cnt_nxt   = aescbc_pkg::KeyIdxW'(1);
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.kidx = (sts.mode == aescbc_pkg::MODE_DEC)
                   ? aescbc_pkg::KeyIdxW'(aescbc_pkg::NumRounds) - cnt_r : cnt_r;
        cmd.last = last_rnd;
        // final round waits for the output register to free up
        if (!last_rnd) begin
          cmd.round = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
        end else if (sts.out_free) begin
          cmd.round = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      dirty_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      dirty_r <= dirty_nxt;
    end
  end

  a_round_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND) |-> (cnt_r >= 1 && cnt_r <= aescbc_pkg::NumRounds))
    else $error("round counter out of range");

  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (state_r == S_KEXP || state_r == S_LOAD))
    else $error("accepted beat did not start work");

  a_kexp_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_KEXP) |-> !dirty_r)
    else $error("key expansion running with stale flag");

  a_last_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.round && cmd.last) |-> sts.out_free)
    else $error("result written over a pending beat");

endmodule

FILE: design/aescbc_dp.sv
// aescbc_dp: config registers, round key store, cipher state, chain and output register.
// Depends on aescbc_pkg.
module aescbc_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [aescbc_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [63:0]                       cfg_data,
  input  logic                              in_mode,
  input  logic                              in_first_block,
  input  logic [63:0]                       in_block_high,
  input  logic [63:0]                       in_block_low,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [63:0]                       out_result_high,
  output logic [63:0]                       out_result_low,
  input  aescbc_pkg::cmd_t                  cmd,
  output aescbc_pkg::status_t               sts
);

  logic [127:0] key_r, iv_r, chain_r, blk_r, st_r, kw_r, res_r;
  logic [127:0] rk_r [0:aescbc_pkg::NumRounds];
  logic [7:0]   rc_r;
  logic         mode_r;
  logic         ovld_r;
  logic [127:0] rk, knew, enc_t, dec_t, rnd, res;

  assign rk   = rk_r[cmd.kidx];
  assign knew = aescbc_pkg::key_next(kw_r, rc_r);

  always_comb begin
    enc_t = aescbc_pkg::shift_rows(aescbc_pkg::sub_bytes(st_r, 1'b0), 1'b0);
    if (!cmd.last) begin
      enc_t = aescbc_pkg::mix_columns(enc_t, 1'b0);
    end
    enc_t = enc_t ^ rk;
    dec_t = aescbc_pkg::sub_bytes(aescbc_pkg::shift_rows(st_r, 1'b1), 1'b1) ^ rk;
    if (!cmd.last) begin
      dec_t = aescbc_pkg::mix_columns(dec_t, 1'b1);
    end
    rnd = (mode_r == aescbc_pkg::MODE_DEC) ? dec_t : enc_t;
    res = (mode_r == aescbc_pkg::MODE_DEC) ? (rnd ^ chain_r) : rnd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= '0;
      iv_r    <= '0;
      chain_r <= '0;
      ovld_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          aescbc_pkg::REG_KEY_HIGH: key_r[127:64] <= cfg_data;
          aescbc_pkg::REG_KEY_LOW:  key_r[63:0]   <= cfg_data;
          aescbc_pkg::REG_IV_HIGH:  iv_r[127:64]  <= cfg_data;
          aescbc_pkg::REG_IV_LOW:   iv_r[63:0]    <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.accept && in_first_block) begin
        chain_r <= iv_r;
      end
      if (cmd.round && cmd.last) begin
        chain_r <= (mode_r == aescbc_pkg::MODE_DEC) ? blk_r : rnd;
        ovld_r  <= 1'b1;
      end else if (out_ready) begin
        ovld_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      blk_r  <= {in_block_high, in_block_low};
      mode_r <= in_mode;
    end
    if (cmd.kinit) begin
      kw_r     <= key_r;
      rk_r[0]  <= key_r;
      rc_r     <= aescbc_pkg::RC_FIRST;
    end
    if (cmd.kstep) begin
      kw_r          <= knew;
      rk_r[cmd.kidx] <= knew;
      rc_r          <= aescbc_pkg::xt(rc_r);
    end
    if (cmd.load) begin
      st_r <= (mode_r == aescbc_pkg::MODE_DEC) ? (blk_r ^ rk) : (blk_r ^ chain_r ^ rk);
    end
    if (cmd.round) begin
      st_r <= rnd;
    end
    if (cmd.round && cmd.last) begin
      res_r <= res;
    end
  end

  assign out_valid       = ovld_r;
  assign out_result_high = res_r[127:64];
  assign out_result_low  = res_r[63:0];

  assign sts.out_free = !ovld_r || out_ready;
  assign sts.mode     = mode_r;
  assign sts.key_wr   = cfg_valid && (cfg_index == aescbc_pkg::REG_KEY_HIGH ||
                                      cfg_index == aescbc_pkg::REG_KEY_LOW);

endmodule

FILE: design/aes128_cbc_block_cipher.sv
// aes128_cbc_block_cipher: top level, aes-128 in cbc mode on 128-bit blocks.
// Depends on aescbc_pkg, aescbc_ctrl and aescbc_dp.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes key_high (0),
//   key_low (1), iv_high (2), iv_low (3); other indexes are ignored. cfg_ready
//   is always high. Write only while the block is idle.
//   in channel takes one block per beat: mode (0 encrypt, 1 decrypt),
//   first_block (reload the chain from the iv) and the two block halves.
//   out channel returns one result block per input beat, in order.
// Timing:
//   out_valid rises after the input beat is accepted, once the block has
//   run the load/whitening step and ten rounds in the single round unit.
//   in_ready comes back with out_valid, so the next block is accepted only
//   after the last one has finished its final round.
//   After a key write the next block first expands the round keys, one per
//   cycle. One block is in flight at a time.
// Reset: key, iv and chain clear to zero; the zero key is expanded on the
//   first block. If the receiver stalls, the result waits in the output
//   register; the next block is accepted and runs up to its final round,
//   where it holds until the output register is free.
module aes128_cbc_block_cipher (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [aescbc_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [63:0]                       cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_mode,
  input  logic                              in_first_block,
  input  logic [63:0]                       in_block_high,
  input  logic [63:0]                       in_block_low,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [63:0]                       out_result_high,
  output logic [63:0]                       out_result_low
);

  aescbc_pkg::cmd_t    cmd;
  aescbc_pkg::status_t sts;

  assign cfg_ready = 1'b1;

  aescbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  aescbc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_mode         (in_mode),
    .in_first_block  (in_first_block),
    .in_block_high   (in_block_high),
    .in_block_low    (in_block_low),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_high (out_result_high),
    .out_result_low  (out_result_low),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule
